/* sv/ffpa_pkg.sv */
// shared types and codes for the first-fit page allocator
`default_nettype none

package ffpa_pkg;

    // request kinds
    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_CHECK = 2'd2;

    // response status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_BOUNDS   = 2'd2;
    localparam logic [1:0] STATUS_NOT_USED = 2'd3;

    // page index arithmetic width, set by the byte field widths
    localparam int DIV_W = 22;

    typedef struct packed {
        logic [1:0]  kind;
        logic [19:0] byte_offset;
        logic [20:0] byte_length;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] first_page;
        logic [8:0] page_count;
        logic       double_free;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_SCAN,
        ST_WALK,
        ST_MARK,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* sv/first_fit_page_allocator_top.sv */
// first-fit page allocator over a one-bit-per-page used map
//
// Requests come in on s_valid/s_ready with an s_data struct (kind, byte_offset,
// byte_length); one response per request leaves on m_valid/m_ready in m_data.
// s_ready is high only while the sequencer is idle, one request at a time.
// The used map is a PAGE_COUNT x 1 memory with a registered read port; a
// shared reciprocal multiplier turns a byte value into a page number, and the
// map is walked one page per cycle.
// Allocate: the map is scanned, then the pages allocated are marked used,
// where the scan stops at the end of the first free run that is long enough;
// the whole map is scanned when there is no space.
// Free and check walk the pages in the range; kind 3 or a range past the
// heap end answers without a walk.
// s_ready rises again in the same cycle that m_valid rises with the response.
// After reset a clearing pass writes every page free, with s_ready low.
// The response sits in an output register; a stalled receiver holds it there
// while the next request is taken and worked, and that request then waits
// in its final state until the register frees up.
`default_nettype none

module first_fit_page_allocator_top #(
    parameter int PAGE_COUNT = 256,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire ffpa_pkg::req_t  s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output ffpa_pkg::rsp_t       m_data
);
    import ffpa_pkg::*;

    localparam int IDX_W  = $clog2(PAGE_COUNT);
    localparam int CNT_W  = IDX_W + 1;
    localparam int RCP_SH = DIV_W + $clog2(PAGE_BYTES);
    localparam int RCP_W  = DIV_W + 2;
    localparam int PROD_W = DIV_W + RCP_W;

    localparam logic [32:0]       HEAP_BYTES = 33'(PAGE_COUNT) * 33'(PAGE_BYTES);
    localparam logic [DIV_W-1:0]  PB_M1      = DIV_W'(PAGE_BYTES - 1);
    localparam logic [CNT_W-1:0]  PC         = CNT_W'(PAGE_COUNT);
    localparam logic [CNT_W-1:0]  PC_M1      = CNT_W'(PAGE_COUNT - 1);
    localparam logic [63:0]       RCP_FULL   =
        ((64'd1 << RCP_SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
    localparam logic [RCP_W-1:0]  RCP        = RCP_W'(RCP_FULL);

    state_t state_reg, state_next;

    logic [1:0]        kind_reg, kind_next;
    logic [19:0]       off_reg, off_next;
    logic [20:0]       len_reg, len_next;
    logic [DIV_W-1:0]  end_reg, end_next;

    logic [DIV_W-1:0]  div_q_reg, div_q_next;
    logic              div_second_reg, div_second_next;

    logic [DIV_W-1:0]  want_reg, want_next;
    logic [CNT_W-1:0]  first_reg, first_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic [CNT_W-1:0]  lim_reg, lim_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic              pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]  pipe_addr_reg, pipe_addr_next;
    logic              any_free_reg, any_free_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  stop_reg, stop_next;
    logic [CNT_W-1:0]  clr_reg, clr_next;

    logic [1:0]        res_status_reg, res_status_next;
    logic [CNT_W-1:0]  res_first_reg, res_first_next;
    logic [CNT_W-1:0]  res_count_reg, res_count_next;
    logic              res_dbl_reg, res_dbl_next;

    logic              m_valid_reg, m_valid_next;
    rsp_t              m_data_reg, m_data_next;

    // used map
    logic              page_mem [PAGE_COUNT];
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic              mem_rd_data_reg;
    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    logic              mem_wr_data;

    // shared page number unit
    logic [PROD_W-1:0] q_prod;
    logic [DIV_W-1:0]  q_step;

    // walk helpers
    logic              issue;
    logic [CNT_W-1:0]  run_inc;
    logic              run_hit;
    logic [IDX_W-1:0]  run_start;
    logic [20:0]       alloc_len;
    logic              out_free;
    logic [31:0]       first_ext;
    logic [31:0]       count_ext;

    assign q_prod = PROD_W'(div_q_reg) * PROD_W'(RCP);
    assign q_step = DIV_W'(q_prod >> RCP_SH);

    assign issue     = (iss_reg != lim_reg);
    assign run_inc   = run_reg + 1'b1;
    assign run_hit   = (DIV_W'(run_inc) == want_reg);
    assign run_start = pipe_addr_reg - run_reg[IDX_W-1:0];
    assign alloc_len = (len_reg == 21'd0) ? 21'd4 : len_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign first_ext = 32'(res_first_reg);
    assign count_ext = 32'(res_count_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == PC_M1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (kind_reg == KIND_ALLOC) begin
                    state_next = ST_DIV;
                end else if ((kind_reg == KIND_FREE || kind_reg == KIND_CHECK)
                             && !({11'd0, end_reg} > HEAP_BYTES)) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                if (kind_reg == KIND_ALLOC) begin
                    state_next = ST_SCAN;
                end else if (div_second_reg) begin
                    state_next = ST_WALK;
                end
            end
            ST_SCAN: begin
                if (pipe_vld_reg) begin
                    if (!mem_rd_data_reg && run_hit) begin
                        state_next = ST_MARK;
                    end
                end else if (!issue) begin
                    state_next = ST_DONE;
                end
            end
            ST_WALK: begin
                if (!pipe_vld_reg && !issue) begin
                    state_next = ST_DONE;
                end
            end
            ST_MARK: begin
                if (cur_reg == stop_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake and memory controls
    always_comb begin
        s_ready     = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = iss_reg[IDX_W-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = iss_reg[IDX_W-1:0];
        mem_wr_data = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg[IDX_W-1:0];
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_SCAN: begin
                mem_rd_en = issue;
            end
            ST_WALK: begin
                mem_rd_en = issue;
                mem_wr_en = issue && (kind_reg == KIND_FREE);
            end
            ST_MARK: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cur_reg;
                mem_wr_data = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        kind_next       = kind_reg;
        off_next        = off_reg;
        len_next        = len_reg;
        end_next        = end_reg;
        div_q_next      = div_q_reg;
        div_second_next = div_second_reg;
        want_next       = want_reg;
        first_next      = first_reg;
        iss_next        = iss_reg;
        lim_next        = lim_reg;
        run_next        = run_reg;
        pipe_vld_next   = 1'b0;
        pipe_addr_next  = iss_reg[IDX_W-1:0];
        any_free_next   = any_free_reg;
        cur_next        = cur_reg;
        stop_next       = stop_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        res_count_next  = res_count_reg;
        res_dbl_next    = res_dbl_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE: begin
                kind_next = s_data.kind;
                off_next  = s_data.byte_offset;
                len_next  = s_data.byte_length;
                end_next  = DIV_W'(s_data.byte_offset) + DIV_W'(s_data.byte_length);
            end
            ST_PREP: begin
                div_second_next = 1'b0;
                res_status_next = STATUS_BOUNDS;
                res_first_next  = '0;
                res_count_next  = '0;
                res_dbl_next    = 1'b0;
                if (kind_reg == KIND_ALLOC) begin
                    div_q_next = DIV_W'(alloc_len) + PB_M1;
                end else begin
                    div_q_next = DIV_W'(off_reg);
                end
            end
            ST_DIV: begin
                if (kind_reg == KIND_ALLOC) begin
                    want_next = q_step;
                    iss_next  = '0;
                    lim_next  = PC;
                    run_next  = '0;
                end else if (!div_second_reg) begin
                    first_next      = q_step[CNT_W-1:0];
                    div_q_next      = end_reg + PB_M1;
                    div_second_next = 1'b1;
                end else begin
                    iss_next      = first_reg;
                    lim_next      = q_step[CNT_W-1:0];
                    any_free_next = 1'b0;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    iss_next      = iss_reg + 1'b1;
                    pipe_vld_next = 1'b1;
                end
                if (pipe_vld_reg) begin
                    if (!mem_rd_data_reg) begin
                        run_next = run_inc;
                        if (run_hit) begin
                            res_status_next = STATUS_OK;
                            res_first_next  = CNT_W'(run_start);
                            res_count_next  = run_inc;
                            cur_next        = run_start;
                            stop_next       = pipe_addr_reg;
                        end
                    end else begin
                        run_next = '0;
                    end
                end else if (!issue) begin
                    res_status_next = STATUS_NO_SPACE;
                end
            end
            ST_WALK: begin
                if (issue) begin
                    iss_next      = iss_reg + 1'b1;
                    pipe_vld_next = 1'b1;
                end
                if (pipe_vld_reg && !mem_rd_data_reg) begin
                    any_free_next = 1'b1;
                end
                if (!pipe_vld_reg && !issue) begin
                    res_first_next = first_reg;
                    res_count_next = lim_reg - first_reg;
                    res_dbl_next   = (kind_reg == KIND_FREE) && any_free_reg;
                    if ((kind_reg == KIND_CHECK) && any_free_reg) begin
                        res_status_next = STATUS_NOT_USED;
                    end else begin
                        res_status_next = STATUS_OK;
                    end
                end
            end
            ST_MARK: begin
                cur_next = cur_reg + 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = res_status_reg;
                    m_data_next.first_page  = first_ext[7:0];
                    m_data_next.page_count  = count_ext[8:0];
                    m_data_next.double_free = res_dbl_reg;
                end
            end
            default: begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            m_valid_reg  <= 1'b0;
            pipe_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_valid_reg  <= m_valid_next;
            pipe_vld_reg <= pipe_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        off_reg        <= off_next;
        len_reg        <= len_next;
        end_reg        <= end_next;
        div_q_reg      <= div_q_next;
        div_second_reg <= div_second_next;
        want_reg       <= want_next;
        first_reg      <= first_next;
        iss_reg        <= iss_next;
        lim_reg        <= lim_next;
        run_reg        <= run_next;
        pipe_addr_reg  <= pipe_addr_next;
        any_free_reg   <= any_free_next;
        cur_reg        <= cur_next;
        stop_reg       <= stop_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        res_count_reg  <= res_count_next;
        res_dbl_reg    <= res_dbl_next;
        m_data_reg     <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            mem_rd_data_reg <= page_mem[mem_rd_addr];
        end
        if (mem_wr_en) begin
            page_mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // marking never runs past the end of the found run
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MARK |-> cur_reg <= stop_reg)
        else $error("mark pointer passed end of run");

    // a free run shorter than the request is all the scan may hold
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> DIV_W'(run_reg) < want_reg)
        else $error("run counter reached request without stopping");

    // range walk stays inside the map
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> (iss_reg <= lim_reg) && (lim_reg <= PC))
        else $error("range walk outside page map");

    // a stalled response holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_data_reg))
        else $error("response changed while stalled");

endmodule

`default_nettype wire

/* dv/first_fit_page_allocator_top_test.sv */
// self-checking testbench for the first-fit page allocator: directed and random requests
module first_fit_page_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ffpa_pkg::*;

    localparam int PAGE_COUNT = 256;
    localparam int PAGE_BYTES = 4096;
    localparam int HEAP_BYTES = PAGE_COUNT * PAGE_BYTES;
    localparam int RANDOM_REQS = 630;
    localparam int CALM_TAIL = 80;
    localparam int DRAIN_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    typedef struct {
        int first;
        int count;
    } run_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    logic [PAGE_COUNT-1:0] page_map = '0;
    run_t live_runs[$];
    req_t pending_reqs[$];
    rsp_t expected_rsps[$];

    logic src_idle_en = 1'b0;
    logic sink_idle_en = 1'b0;
    int src_gap = 0;
    int sink_gap = 0;
    int quiet_cycles = 0;
    int queued = 0;
    int accepted = 0;
    int rsp_seen = 0;
    int errors = 0;
    int n_alloc_ok = 0;
    int n_no_space = 0;
    int n_freed = 0;
    int n_double = 0;
    int n_checked = 0;
    int n_not_used = 0;
    int n_bounds = 0;

    first_fit_page_allocator_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic rsp_t allocator_response(input req_t rq);
        rsp_t rs;
        int want, run, pg, first, last, endb, idx;
        logic any_free;
        rs = '0;
        any_free = 1'b0;
        if (rq.kind == KIND_ALLOC) begin
            want = (rq.byte_length == '0) ? 1
                 : (int'(rq.byte_length) + PAGE_BYTES - 1) / PAGE_BYTES;
            rs.status = STATUS_NO_SPACE;
            run = 0;
            for (pg = 0; pg < PAGE_COUNT && rs.status != STATUS_OK; pg++) begin
                run = page_map[pg] ? 0 : run + 1;
                if (run == want) begin
                    first = pg - want + 1;
                    for (idx = first; idx <= pg; idx++) page_map[idx] = 1'b1;
                    rs.status = STATUS_OK;
                    rs.first_page = 8'(first);
                    rs.page_count = 9'(want);
                    live_runs.push_back('{first, want});
                    n_alloc_ok++;
                end
            end
            if (rs.status == STATUS_NO_SPACE) n_no_space++;
        end else if (rq.kind == KIND_FREE || rq.kind == KIND_CHECK) begin
            endb = int'(rq.byte_offset) + int'(rq.byte_length);
            if (endb > HEAP_BYTES) begin
                rs.status = STATUS_BOUNDS;
                n_bounds++;
            end else begin
                first = int'(rq.byte_offset) / PAGE_BYTES;
                last = (endb + PAGE_BYTES - 1) / PAGE_BYTES;
                if (last < first) last = first;
                for (pg = first; pg < last; pg++) begin
                    if (!page_map[pg]) any_free = 1'b1;
                end
                rs.first_page = 8'(first);
                rs.page_count = 9'(last - first);
                if (rq.kind == KIND_FREE) begin
                    for (pg = first; pg < last; pg++) page_map[pg] = 1'b0;
                    rs.double_free = any_free;
                    idx = 0;
                    while (idx < live_runs.size()) begin
                        if (live_runs[idx].first >= first && live_runs[idx].first < last)
                            live_runs.delete(idx);
                        else
                            idx++;
                    end
                    n_freed++;
                    if (any_free) n_double++;
                end else begin
                    rs.status = any_free ? STATUS_NOT_USED : STATUS_OK;
                    n_checked++;
                    if (any_free) n_not_used++;
                end
            end
        end else begin
            rs.status = STATUS_BOUNDS;
            n_bounds++;
        end
        return rs;
    endfunction

    // mostly allocations and frees/checks of live runs, plus random ranges
    function automatic req_t random_request();
        req_t rq;
        int pick, idx, lo_page, npages, off, endb;
        pick = $urandom_range(0, 99);
        rq.kind = KIND_ALLOC;
        rq.byte_offset = 20'($urandom());
        rq.byte_length = 21'($urandom_range(0, 4 * PAGE_BYTES));
        if (pick < 40) begin
            case ($urandom_range(0, 9))
                7, 8: rq.byte_length = 21'($urandom_range(0, 32 * PAGE_BYTES));
                9: rq.byte_length = 21'($urandom());
                default: ;
            endcase
        end else if (pick < 82 && live_runs.size() > 0) begin
            idx = $urandom_range(0, live_runs.size() - 1);
            lo_page = live_runs[idx].first;
            npages = live_runs[idx].count;
            rq.kind = (pick < 68) ? KIND_FREE : KIND_CHECK;
            if ($urandom_range(0, 3) != 0) begin
                off = lo_page * PAGE_BYTES;
                endb = (lo_page + npages) * PAGE_BYTES - $urandom_range(0, PAGE_BYTES - 1);
            end else begin
                off = lo_page * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1);
                endb = (lo_page + npages) * PAGE_BYTES;
            end
            rq.byte_offset = 20'(off);
            rq.byte_length = 21'(endb - off);
        end else begin
            rq.kind = 2'($urandom_range(1, 3));
            if ($urandom_range(0, 3) == 0) rq.byte_length = 21'($urandom());
        end
        return rq;
    endfunction

    task automatic push_req(input req_t rq);
        pending_reqs.push_back(rq);
        queued++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_rsps.push_back(allocator_response(s_data));
                accepted++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    s_valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end else if (pending_reqs.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= pending_reqs.pop_front();
                    if (src_idle_en && $urandom_range(0, 3) == 0)
                        src_gap <= $urandom_range(1, 18);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : response_check
        rsp_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                rsp_seen++;
                if (expected_rsps.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected response %p", m_data);
                end else begin
                    want = expected_rsps.pop_front();
                    if (m_data.status !== want.status
                            || m_data.first_page !== want.first_page
                            || m_data.page_count !== want.page_count
                            || m_data.double_free !== want.double_free) begin
                        errors++;
                        if (errors <= 10)
                            $display("response %0d wrong: expected %p, got %p",
                                     rsp_seen, want, m_data);
                    end
                end
            end
            if (sink_gap > 0) begin
                m_ready <= 1'b0;
                sink_gap <= sink_gap - 1;
            end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                sink_gap <= $urandom_range(1, 18) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("first_fit_page_allocator_top: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // small allocations, rounding and zero length
        push_req('{KIND_ALLOC, 20'd0, 21'd0});
        push_req('{KIND_ALLOC, 20'd0, 21'd1});
        push_req('{KIND_ALLOC, 20'd0, 21'd4096});
        push_req('{KIND_ALLOC, 20'd0, 21'd4097});
        // more pages than the map holds or has free, then checks, a free and a double free
        push_req('{KIND_ALLOC, 20'd0, 21'h1FFFFF});
        push_req('{KIND_ALLOC, 20'd0, 21'd1048576});
        push_req('{KIND_CHECK, 20'd0, 21'd20480});
        push_req('{KIND_CHECK, 20'd0, 21'd24576});
        push_req('{KIND_FREE, 20'd4096, 21'd1});
        push_req('{KIND_FREE, 20'd4096, 21'd4096});
        // zero length at unaligned and aligned offsets
        push_req('{KIND_CHECK, 20'd4097, 21'd0});
        push_req('{KIND_CHECK, 20'd8192, 21'd0});
        // last byte of the heap, then one past it, then the reserved kind
        push_req('{KIND_FREE, 20'hFFFFF, 21'd1});
        push_req('{KIND_CHECK, 20'hFFFFF, 21'd1});
        push_req('{KIND_FREE, 20'hFFFFF, 21'd2});
        push_req('{KIND_CHECK, 20'd0, 21'd1048577});
        push_req('{KIND_CHECK, 20'd0, 21'h1FFFFF});
        push_req('{KIND_RESERVED, 20'hFFFFF, 21'h1FFFFF});
        push_req('{KIND_RESERVED, 20'd0, 21'd0});
        // whole heap free, allocate, check, then full map, free, allocate again
        push_req('{KIND_FREE, 20'd0, 21'd1048576});
        push_req('{KIND_ALLOC, 20'd0, 21'd1048576});
        push_req('{KIND_CHECK, 20'd0, 21'd1048576});
        push_req('{KIND_ALLOC, 20'd0, 21'd0});
        push_req('{KIND_FREE, 20'd0, 21'd1048576});
        push_req('{KIND_ALLOC, 20'hFFFFF, 21'd8192});

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < RANDOM_REQS; i++) begin
            while (pending_reqs.size() >= 4) @(negedge aclk);
            if (i % 60 == 0) begin
                src_idle_en = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
            end
            if (i >= RANDOM_REQS - CALM_TAIL) begin
                src_idle_en = 1'b0;
                sink_idle_en = 1'b0;
            end
            push_req(random_request());
        end

        while (accepted < queued || rsp_seen < queued) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (expected_rsps.size() != 0) begin
            errors += expected_rsps.size();
            $display("%0d responses never arrived", expected_rsps.size());
        end
        $display("run covered %0d requests: %0d allocations granted, %0d out of space",
                 queued, n_alloc_ok, n_no_space);
        $display("%0d frees (%0d double), %0d checks (%0d hit free pages), %0d rejected",
                 n_freed, n_double, n_checked, n_not_used, n_bounds);
        if (errors == 0) begin
            $display("first_fit_page_allocator_top: match");
        end else begin
            $display("first_fit_page_allocator_top: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/ffpa_pkg.sv
sv/first_fit_page_allocator_top.sv
dv/first_fit_page_allocator_top_test.sv
